@@ sv/art_pkg.sv @@
// Shared codes and default sizes for the address region table.
`timescale 1ns / 1ps
package art_pkg;

  localparam int MAX_REGIONS_DEF = 32;
  localparam int PAGE_BITS_DEF   = 12;

  // operation codes (s_axis_tuser)
  localparam logic [2:0] MODE_FIXED  = 3'd0;
  localparam logic [2:0] MODE_ASC    = 3'd1;
  localparam logic [2:0] MODE_DESC   = 3'd2;
  localparam logic [2:0] MODE_UNMAP  = 3'd3;
  localparam logic [2:0] MODE_PROT   = 3'd4;
  localparam logic [2:0] MODE_LOOKUP = 3'd5;

  // status codes (m_axis_tuser)
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERLAP  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_UNMAPPED = 3'd3;
  localparam logic [2:0] ST_NOSPACE  = 3'd4;

endpackage

@@ sv/art_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps
module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/address_region_table.sv @@
// Address region table: sorted page-aligned regions with map, unmap, protect, lookup.
// One operation at a time: the next beat is taken in the cycle after the result loads;
//   the table is walked entry by entry through the single RAM read port.
// Reset clears the region count, bank select and output valid; table RAM is not cleared.
`timescale 1ns / 1ps
module address_region_table
  import art_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF,
  parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: addr[63:0], range_end[127:64], size[191:128], perms[194:192], zero fill
  input  logic [199:0] s_axis_tdata,
  // tuser: mode[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: result_addr[63:0], region_end[127:64], region_perms[130:128], zero fill
  output logic [135:0] m_axis_tdata,
  // tuser: status[2:0]
  output logic [2:0]   m_axis_tuser
);

  localparam int PW = 64 - PAGE_BITS;                  // page number width
  localparam int IW = $clog2(MAX_REGIONS);             // entry index width
  localparam int CW = $clog2(MAX_REGIONS + 3) + 1;     // count / write pointer width
  localparam int WW = 2 * PW + 3;                      // RAM word: rights, end, start
  localparam int RD = 2 << IW;                         // two banks
  localparam logic [63:0]   PG_MASK = (64'd1 << PAGE_BITS) - 64'd1;
  localparam logic [CW-1:0] MAXC    = CW'(MAX_REGIONS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_PUSH   = 4'd4;
  localparam logic [3:0] S_SEND   = 4'd5;
  localparam logic [3:0] S_MSTART = 4'd6;
  localparam logic [3:0] S_MEND   = 4'd7;
  localparam logic [3:0] S_REND   = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  localparam logic [1:0] P_SRCH = 2'd0;
  localparam logic [1:0] P_MAP  = 2'd1;
  localparam logic [1:0] P_REW  = 2'd2;
  localparam logic [1:0] P_LOOK = 2'd3;

  // round a byte value up to pages; top bit flags a wrap past 2^64
  function automatic logic [PW:0] rnd(input logic [63:0] v);
    logic [63:0] sh;
    sh = v >> PAGE_BITS;
    return {1'b0, sh[PW-1:0]} + (PW+1)'(|(v & PG_MASK));
  endfunction

  function automatic logic [63:0] to_bytes(input logic [PW-1:0] p);
    return 64'(p) << PAGE_BITS;
  endfunction

  // control
  logic [3:0]    state, state_next;
  logic [1:0]    pass, pass_next;
  logic          bank, bank_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] widx, widx_next;
  logic          hit, hit_next;
  logic          ins, ins_next;
  logic [2:0]    pmask, pmask_next;

  // operands and working values
  logic [2:0]    mode_r, perms_r;
  logic [PW-1:0] addr_pg, a_pg, e_pg, s_pg;
  logic          wrap_a, wrap_e, wrap_s;
  logic [PW-1:0] cur, cur_next;
  logic [PW-1:0] new_s, new_s_next, new_e, new_e_next;
  logic [PW-1:0] ent_s, ent_e;
  logic [2:0]    ent_r;
  logic [2:0]    res_status, res_status_next;
  logic [63:0]   res_addr, res_addr_next, res_end, res_end_next;
  logic [2:0]    res_perms, res_perms_next;

  // input rounding
  logic [PW:0] in_a, in_e, in_s;
  assign in_a = rnd(s_axis_tdata[63:0]);
  assign in_e = rnd(s_axis_tdata[127:64]);
  assign in_s = rnd(s_axis_tdata[191:128]);

  // table RAM
  logic          we;
  logic [IW:0]   waddr, raddr;
  logic [WW-1:0] wdata, rdata;
  logic [PW-1:0] rs, re;
  logic [2:0]    rr;

  art_ram #(.WIDTH(WW), .DEPTH(RD)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign raddr = {bank, idx[IW-1:0]};
  assign rs    = rdata[PW-1:0];
  assign re    = rdata[2*PW-1:PW];
  assign rr    = rdata[WW-1:2*PW];

  // two adders: cursor plus size, and start plus size
  logic [PW:0] cur_plus_s, a_plus_s;
  assign cur_plus_s = {1'b0, cur} + {1'b0, s_pg};
  assign a_plus_s   = {1'b0, a_pg} + {1'b0, s_pg};

  logic desc_walk, last;
  assign desc_walk = (pass == P_SRCH) && (mode_r == MODE_DESC);
  assign last      = desc_walk ? (idx == '0) : (idx == count - CW'(1));

  // range overlap of the fetched entry and of the latched entry
  logic rd_ovl, ent_ovl;
  assign rd_ovl  = !(re <= a_pg || rs >= e_pg);
  assign ent_ovl = !(ent_e <= a_pg || ent_s >= e_pg);

  // piece selected for the next write
  logic [PW-1:0] pc_s, pc_e;
  logic [2:0]    pc_r;
  logic [2:0]    pick;
  always_comb begin
    pick = pmask & ~(pmask - 3'd1);
    pc_s = ent_s;
    pc_e = ent_e;
    pc_r = ent_r;
    if (pass == P_MAP) begin
      if (pick[0]) begin
        pc_s = new_s;
        pc_e = new_e;
        pc_r = perms_r;
      end
    end else begin
      case (pick)
        3'b001: begin
          pc_e = ent_ovl ? a_pg : ent_e;
        end
        3'b010: begin
          pc_s = (ent_s > a_pg) ? ent_s : a_pg;
          pc_e = (ent_e < e_pg) ? ent_e : e_pg;
          pc_r = perms_r;
        end
        3'b100: begin
          pc_s = e_pg;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next      = state;
    pass_next       = pass;
    bank_next       = bank;
    count_next      = count;
    idx_next        = idx;
    widx_next       = widx;
    hit_next        = hit;
    ins_next        = ins;
    pmask_next      = pmask;
    cur_next        = cur;
    new_s_next      = new_s;
    new_e_next      = new_e;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    res_end_next    = res_end;
    res_perms_next  = res_perms;
    we    = 1'b0;
    waddr = {~bank, widx[IW-1:0]};
    wdata = {pc_r, pc_e, pc_s};

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next      = S_START;
          res_status_next = ST_OK;
          res_addr_next   = '0;
          res_end_next    = '0;
          res_perms_next  = '0;
        end
      end

      S_START: begin
        idx_next  = '0;
        widx_next = '0;
        hit_next  = 1'b0;
        ins_next  = 1'b0;
        cur_next  = a_pg;
        state_next = S_FIN;
        if (mode_r == MODE_FIXED) begin
          if (wrap_a || wrap_s || s_pg == '0 || a_plus_s[PW]) begin
            res_status_next = ST_NOSPACE;
          end else begin
            new_s_next = a_pg;
            new_e_next = a_plus_s[PW-1:0];
            state_next = S_MSTART;
          end
        end else if (mode_r == MODE_ASC || mode_r == MODE_DESC) begin
          if (wrap_a || wrap_s || s_pg == '0) begin
            res_status_next = ST_NOSPACE;
          end else begin
            pass_next  = P_SRCH;
            idx_next   = (mode_r == MODE_DESC) ? count - CW'(1) : '0;
            state_next = (count == '0) ? S_SEND : S_RD;
          end
        end else if (mode_r == MODE_UNMAP || mode_r == MODE_PROT) begin
          if (wrap_a || wrap_e) begin
            res_status_next = ST_NOSPACE;
          end else if (a_pg >= e_pg) begin
            res_status_next = ST_UNMAPPED;
          end else begin
            pass_next  = P_REW;
            state_next = (count == '0) ? S_REND : S_RD;
          end
        end else if (mode_r == MODE_LOOKUP) begin
          if (count == '0) begin
            res_status_next = ST_UNMAPPED;
          end else begin
            pass_next  = P_LOOK;
            state_next = S_RD;
          end
        end
      end

      S_RD: begin
        state_next = S_CHK;
      end

      S_CHK, S_PUSH: begin
        logic adv;
        adv = 1'b0;
        if (state == S_PUSH) begin
          we         = widx < MAXC;
          widx_next  = widx + CW'(1);
          pmask_next = pmask & ~pick;
          adv        = (pmask_next == '0);
        end else begin
          case (pass)
            P_SRCH: begin
              adv = 1'b1;
              if (mode_r == MODE_ASC) begin
                if (re > cur) begin
                  if (rs >= cur && {1'b0, rs} >= cur_plus_s) begin
                    new_s_next = cur;
                    new_e_next = cur_plus_s[PW-1:0];
                    state_next = S_MSTART;
                    adv        = 1'b0;
                  end else begin
                    cur_next = re;
                  end
                end
              end else begin
                if (rs < cur) begin
                  if (re <= cur && {1'b0, re} + {1'b0, s_pg} <= {1'b0, cur}) begin
                    new_s_next = cur - s_pg;
                    new_e_next = cur;
                    state_next = S_MSTART;
                    adv        = 1'b0;
                  end else begin
                    cur_next = rs;
                  end
                end
              end
            end
            P_MAP: begin
              if (rs < new_e && re > new_s) begin
                res_status_next = ST_OVERLAP;
                state_next      = S_FIN;
              end else begin
                pmask_next = {1'b0, 1'b1, !ins && rs >= new_s};
                ins_next   = ins || (rs >= new_s);
                state_next = S_PUSH;
              end
            end
            P_REW: begin
              hit_next   = hit || rd_ovl;
              pmask_next = {rd_ovl && re > e_pg,
                            rd_ovl && mode_r == MODE_PROT,
                            !rd_ovl || rs < a_pg};
              if (pmask_next == '0) begin
                adv = 1'b1;
              end else begin
                state_next = S_PUSH;
              end
            end
            P_LOOK: begin
              if (addr_pg >= rs && addr_pg < re) begin
                res_addr_next  = to_bytes(rs);
                res_end_next   = to_bytes(re);
                res_perms_next = rr;
                state_next     = S_FIN;
              end else begin
                adv = 1'b1;
              end
            end
            default: ;
          endcase
        end
        if (adv) begin
          if (last) begin
            case (pass)
              P_SRCH: state_next = S_SEND;
              P_MAP:  state_next = S_MEND;
              P_REW:  state_next = S_REND;
              default: begin
                res_status_next = ST_UNMAPPED;
                state_next      = S_FIN;
              end
            endcase
          end else begin
            idx_next   = desc_walk ? idx - CW'(1) : idx + CW'(1);
            state_next = S_RD;
          end
        end
      end

      S_SEND: begin
        state_next = S_MSTART;
        if (mode_r == MODE_ASC) begin
          if (cur_plus_s[PW]) begin
            res_status_next = ST_NOSPACE;
            state_next      = S_FIN;
          end else begin
            new_s_next = cur;
            new_e_next = cur_plus_s[PW-1:0];
          end
        end else begin
          if (s_pg > cur) begin
            res_status_next = ST_NOSPACE;
            state_next      = S_FIN;
          end else begin
            new_s_next = cur - s_pg;
            new_e_next = cur;
          end
        end
      end

      S_MSTART: begin
        pass_next  = P_MAP;
        idx_next   = '0;
        widx_next  = '0;
        ins_next   = 1'b0;
        state_next = (count == '0) ? S_MEND : S_RD;
      end

      S_MEND: begin
        state_next = S_FIN;
        if (count >= MAXC) begin
          res_status_next = ST_FULL;
        end else begin
          we             = !ins;
          wdata          = {perms_r, new_e, new_s};
          count_next     = count + CW'(1);
          bank_next      = ~bank;
          res_addr_next  = to_bytes(new_s);
        end
      end

      S_REND: begin
        state_next = S_FIN;
        if (!hit) begin
          res_status_next = ST_UNMAPPED;
        end else if (widx > MAXC) begin
          res_status_next = ST_FULL;
        end else begin
          count_next = widx;
          bank_next  = ~bank;
        end
      end

      S_FIN: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      bank          <= 1'b0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      bank  <= bank_next;
      count <= count_next;
      if (state == S_FIN && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pass       <= pass_next;
    idx        <= idx_next;
    widx       <= widx_next;
    hit        <= hit_next;
    ins        <= ins_next;
    pmask      <= pmask_next;
    cur        <= cur_next;
    new_s      <= new_s_next;
    new_e      <= new_e_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
    res_end    <= res_end_next;
    res_perms  <= res_perms_next;
    if (state == S_CHK) begin
      ent_s <= rs;
      ent_e <= re;
      ent_r <= rr;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      mode_r  <= s_axis_tuser;
      perms_r <= s_axis_tdata[194:192];
      addr_pg <= PW'(s_axis_tdata[63:0] >> PAGE_BITS);
      a_pg    <= in_a[PW-1:0];
      e_pg    <= in_e[PW-1:0];
      s_pg    <= in_s[PW-1:0];
      wrap_a  <= in_a[PW];
      wrap_e  <= in_e[PW];
      wrap_s  <= in_s[PW];
    end
    if (state == S_FIN && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= {5'd0, res_perms, res_end, res_addr};
    end
  end

  // table never holds more entries than it has room for
  assert property (@(posedge clk) disable iff (rst) count <= MAXC)
    else $error("region count above table size");

  // a write step always has a piece left to write
  assert property (@(posedge clk) disable iff (rst) state == S_PUSH |-> pmask != '0)
    else $error("write step with empty piece mask");

  // an accepted beat always starts the sequencer
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == S_START)
    else $error("accepted beat did not start an operation");

  // the table only changes on a successful commit
  assert property (@(posedge clk) disable iff (rst)
    $past(state) != S_MEND && $past(state) != S_REND |-> $stable(count) && $stable(bank))
    else $error("table changed outside a commit");

endmodule

@@ dv/tb_address_region_table.sv @@
// Testbench for address_region_table: directed and random operations checked against a predictor.
`timescale 1ns / 1ps
module tb_address_region_table;
  import art_pkg::*;

  localparam int          NREG      = MAX_REGIONS_DEF;
  localparam int          PB        = PAGE_BITS_DEF;
  localparam logic [63:0] PG_MASK   = (64'd1 << PB) - 64'd1;
  localparam logic [63:0] PG        = 64'd1 << PB;
  localparam int          LIMIT     = 2000000;
  localparam int          N_RANDOM  = 1300;
  localparam logic [2:0]  MODE_SPARE6 = 3'd6;
  localparam logic [2:0]  MODE_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] base;
    logic [63:0] limit;
    logic [2:0]  rights;
  } answer_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [199:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  address_region_table u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the region table, byte addresses
  logic [63:0] rg_lo [NREG];
  logic [63:0] rg_hi [NREG];
  logic [2:0]  rg_pr [NREG];
  int          rg_n;

  answer_t     answers_due [$];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;

  function automatic bit round_up(input logic [63:0] v, output logic [63:0] r);
    r = v;
    if ((v & PG_MASK) == 0) return 1'b1;
    if (v > ~PG_MASK) return 1'b0;
    r = (v + PG_MASK) & ~PG_MASK;
    return 1'b1;
  endfunction

  function automatic logic [2:0] place(input logic [63:0] a, input logic [63:0] s,
                                       input logic [2:0] p);
    logic [63:0] e;
    int pos;
    if (s == 0 || s > ~a) return ST_NOSPACE;
    e = a + s;
    for (int i = 0; i < rg_n; i++)
      if (rg_lo[i] < e && rg_hi[i] > a) return ST_OVERLAP;
    if (rg_n >= NREG) return ST_FULL;
    pos = 0;
    while (pos < rg_n && rg_lo[pos] < a) pos++;
    for (int j = rg_n; j > pos; j--) begin
      rg_lo[j] = rg_lo[j-1];
      rg_hi[j] = rg_hi[j-1];
      rg_pr[j] = rg_pr[j-1];
    end
    rg_lo[pos] = a;
    rg_hi[pos] = e;
    rg_pr[pos] = p;
    rg_n++;
    return ST_OK;
  endfunction

  function automatic logic [2:0] search_up(input logic [63:0] cur, input logic [63:0] s,
                                           output logic [63:0] at);
    at = 0;
    for (int i = 0; i < rg_n; i++) begin
      if (rg_hi[i] <= cur) continue;
      if (rg_lo[i] >= cur && rg_lo[i] - cur >= s) begin
        at = cur;
        return ST_OK;
      end
      cur = rg_hi[i];
    end
    if (s > ~cur) return ST_NOSPACE;
    at = cur;
    return ST_OK;
  endfunction

  function automatic logic [2:0] search_down(input logic [63:0] top, input logic [63:0] s,
                                             output logic [63:0] at);
    at = 0;
    for (int i = rg_n - 1; i >= 0; i--) begin
      if (rg_lo[i] >= top) continue;
      if (rg_hi[i] <= top && top - rg_hi[i] >= s) begin
        at = top - s;
        return ST_OK;
      end
      top = rg_lo[i];
    end
    if (s > top) return ST_NOSPACE;
    at = top - s;
    return ST_OK;
  endfunction

  function automatic logic [2:0] carve(input logic [63:0] a, input logic [63:0] e,
                                       input bit prot, input logic [2:0] p);
    logic [63:0] ns [NREG+3];
    logic [63:0] ne [NREG+3];
    logic [2:0]  nr [NREG+3];
    int n;
    bit hit;
    n = 0;
    hit = 0;
    if (a >= e) return ST_UNMAPPED;
    for (int i = 0; i < rg_n; i++) begin
      if (rg_hi[i] <= a || rg_lo[i] >= e) begin
        ns[n] = rg_lo[i]; ne[n] = rg_hi[i]; nr[n] = rg_pr[i]; n++;
        continue;
      end
      hit = 1;
      if (rg_lo[i] < a) begin
        ns[n] = rg_lo[i]; ne[n] = a; nr[n] = rg_pr[i]; n++;
      end
      if (prot) begin
        ns[n] = (rg_lo[i] > a) ? rg_lo[i] : a;
        ne[n] = (rg_hi[i] < e) ? rg_hi[i] : e;
        nr[n] = p;
        n++;
      end
      if (rg_hi[i] > e) begin
        ns[n] = e; ne[n] = rg_hi[i]; nr[n] = rg_pr[i]; n++;
      end
    end
    if (!hit) return ST_UNMAPPED;
    if (n > NREG) return ST_FULL;
    for (int i = 0; i < n; i++) begin
      rg_lo[i] = ns[i]; rg_hi[i] = ne[i]; rg_pr[i] = nr[i];
    end
    rg_n = n;
    return ST_OK;
  endfunction

  function automatic answer_t predict_region_op(input logic [2:0] mode, input logic [63:0] addr,
                                                input logic [63:0] range_end,
                                                input logic [63:0] size, input logic [2:0] perms);
    answer_t ans;
    logic [63:0] a, e, s, at;
    ans = '0;
    at = 0;
    if (mode == MODE_FIXED || mode == MODE_ASC || mode == MODE_DESC) begin
      if (!round_up(addr, a) || !round_up(size, s)) ans.status = ST_NOSPACE;
      else if (mode == MODE_FIXED) begin
        ans.status = place(a, s, perms);
        at = a;
      end else if (s == 0) ans.status = ST_NOSPACE;
      else begin
        ans.status = (mode == MODE_ASC) ? search_up(a, s, at) : search_down(a, s, at);
        if (ans.status == ST_OK) ans.status = place(at, s, perms);
      end
      if (ans.status == ST_OK) ans.base = at;
    end else if (mode == MODE_UNMAP || mode == MODE_PROT) begin
      if (!round_up(addr, a) || !round_up(range_end, e)) ans.status = ST_NOSPACE;
      else ans.status = carve(a, e, mode == MODE_PROT, perms);
    end else if (mode == MODE_LOOKUP) begin
      ans.status = ST_UNMAPPED;
      for (int i = 0; i < rg_n; i++)
        if (addr >= rg_lo[i] && addr < rg_hi[i]) begin
          ans.status = ST_OK;
          ans.base   = rg_lo[i];
          ans.limit  = rg_hi[i];
          ans.rights = rg_pr[i];
          break;
        end
    end
    return ans;
  endfunction

  // one beat in; bursts of random length, mostly separated by random gaps
  task automatic send_op(input logic [2:0] mode, input logic [63:0] addr,
                         input logic [63:0] range_end, input logic [63:0] size,
                         input logic [2:0] perms);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {5'b0, perms, size, range_end, addr};
    do @(posedge clk); while (!s_axis_tready);
    answers_due = {answers_due, predict_region_op(mode, addr, range_end, size, perms)};
  endtask

  // result checker with a randomly shifting stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    answer_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ($urandom_range(0, 15) != 0);
    endcase
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (answers_due.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (m_axis_tuser != want.status) begin
          $error("status exp %0d got %0d", want.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[63:0] != want.base) begin
          $error("result_addr exp %h got %h", want.base, m_axis_tdata[63:0]);
          errors++;
        end
        if (m_axis_tdata[127:64] != want.limit) begin
          $error("region_end exp %h got %h", want.limit, m_axis_tdata[127:64]);
          errors++;
        end
        if (m_axis_tdata[130:128] != want.rights) begin
          $error("region_perms exp %0d got %0d", want.rights, m_axis_tdata[130:128]);
          errors++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_fixed_maps();
    send_op(MODE_FIXED, 64'h1000, 0, 64'h2000, 3'd7);
    send_op(MODE_FIXED, 64'h1000, 0, 64'h1000, 3'd1);          // same start
    send_op(MODE_FIXED, 64'h0, 0, 64'h10000, 3'd2);            // encloses existing
    send_op(MODE_FIXED, 64'h3000, 0, 64'h1, 3'd4);             // touches, size rounds up
    send_op(MODE_FIXED, 64'h0, 0, 64'h1000, 3'd0);             // touches below, lowest page
    send_op(MODE_FIXED, 64'hFFFF_FFFF_FFFF_E000, 0, 64'h1000, 3'd5); // page just below the top page
    send_op(MODE_FIXED, 64'hFFFF_FFFF_FFFF_F000, 0, 64'h1000, 3'd5); // would end at 2^64
  endtask

  task automatic test_search_maps();
    send_op(MODE_ASC, 64'h0, 0, 64'h3000, 3'd3);
    send_op(MODE_ASC, 64'h1, 0, 64'h800, 3'd6);
    send_op(MODE_DESC, 64'h8000, 0, 64'h2000, 3'd1);
    send_op(MODE_DESC, 64'h1000, 0, 64'h2000, 3'd1);           // no room below hint
    send_op(MODE_ASC, 64'hFFFF_FFFF_FFFF_C000, 0, 64'h4000, 3'd2); // no room above
    send_op(MODE_ASC, 64'h5000, 0, 64'h0, 3'd2);               // zero size
  endtask

  task automatic test_range_ops();
    send_op(MODE_PROT, 64'h1800, 64'h2800, 0, 3'd0);           // split inside a region
    send_op(MODE_UNMAP, 64'h2000, 64'h2000, 0, 3'd0);          // empty range
    send_op(MODE_UNMAP, 64'h4000_0000, 64'h5000_0000, 0, 3'd0); // hits nothing
    send_op(MODE_UNMAP, 64'hFFFF_FFFF_FFFF_F001, 64'hFFFF_FFFF_FFFF_FFFF, 0, 3'd0); // wrap
    send_op(MODE_FIXED, 64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h1000, 3'd0); // addr wraps
    send_op(MODE_FIXED, 64'h9000_0000, 0, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0); // size wraps
  endtask

  task automatic test_lookups();
    send_op(MODE_LOOKUP, 64'h1FFF, 0, 0, 3'd0);
    send_op(MODE_LOOKUP, 64'h3000_0000, 0, 0, 3'd0);
    send_op(MODE_SPARE6, rand64(), rand64(), rand64(), 3'd7);
    send_op(MODE_SPARE7, 0, 0, 0, 3'd0);
    send_op(MODE_UNMAP, 64'h0, 64'hFFFF_FFFF_FFFF_F000, 0, 3'd0); // clear all
  endtask

  // mostly small page-aligned ops in a few tight windows, so overlaps, splits
  // and a full table come up often; some fully random beats for wrap cases
  task automatic test_random_ops();
    logic [63:0] bases [4];
    logic [63:0] a, e, s, off;
    logic [2:0]  m;
    int pick, map_bias, i;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 150 == 0) begin
        map_bias = $urandom_range(20, 80);
        bases[0] = 0;
        bases[1] = 64'h8000_0000_0000_0000;
        bases[2] = 64'hFFFF_FFFF_FFF0_0000;
        bases[3] = rand64() & ~PG_MASK;
      end
      off  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 4095)) : 64'd0;
      a    = bases[$urandom_range(0, 3)] + $urandom_range(0, 255) * PG + off;
      s    = $urandom_range(1, 8) * PG - (($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : 0);
      e    = a + $urandom_range(1, 40) * PG;
      pick = $urandom_range(0, 99);
      if (pick < map_bias) m = 3'($urandom_range(0, 2));
      else if (pick < 92) m = 3'($urandom_range(3, 5));
      else begin
        m = 3'($urandom_range(0, 7));
        a = rand64();
        e = rand64();
        s = rand64();
      end
      if (m == MODE_LOOKUP && rg_n > 0 && $urandom_range(0, 2) != 0) begin
        i = $urandom_range(0, rg_n - 1);
        a = rg_lo[i] + (rand64() % (rg_hi[i] - rg_lo[i]));
      end
      send_op(m, a, e, s, 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    rg_n = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fixed_maps();
    test_search_maps();
    test_range_ops();
    test_lookups();
    test_random_ops();
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

@@ address_region_table.f @@
sv/art_pkg.sv
sv/art_ram.sv
sv/address_region_table.sv
dv/tb_address_region_table.sv
